// ===== design/sap_pkg.sv =====
// Package for the stereo allpass phaser: widths, fixed-point limits,
// register indexes, handshake structs and sequencer enums.
// No dependencies.
`default_nettype none

package sap_pkg;

    // Field widths
    localparam int SAMPLE_W    = 24;
    localparam int COEF_W      = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int STAGE_CNT_W = 4;

    // Shared unit operand widths: coefficient is one bit wider so that an
    // unsigned mix value up to 65535 stays positive
    localparam int MUL_W   = COEF_W + 1;
    localparam int DIFF_W  = SAMPLE_W + 1;
    localparam int PROD_W  = MUL_W + DIFF_W;
    localparam int Q_SHIFT = 15;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;
    localparam logic signed [MUL_W-1:0]    UNITY_GAIN = 17'sd32768;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STAGE_COUNT   = 2'd2;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0]  RST_FEEDBACK_GAIN = 16'd0;
    localparam logic [CFG_DATA_W-1:0]  RST_WET_MIX       = 16'd32768;
    localparam logic [STAGE_CNT_W-1:0] RST_STAGE_COUNT   = 4'd4;

    typedef struct packed {
        logic signed [COEF_W-1:0]  feedback_gain;
        logic [CFG_DATA_W-1:0]     wet_mix;
        logic [STAGE_CNT_W-1:0]    stage_count;
    } t_cfg;

    // Request to the shared unit: sat(addend + round(coef * (p - q) >> 15))
    typedef struct packed {
        logic                      start;
        logic signed [MUL_W-1:0]   coef;
        logic signed [SAMPLE_W-1:0] p_val;
        logic signed [SAMPLE_W-1:0] q_val;
        logic signed [SAMPLE_W-1:0] addend;
    } t_mac_req;

    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] result;
    } t_mac_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FB,
        S_WETL,
        S_WETR,
        S_RD,
        S_STG,
        S_MEAN,
        S_OUTL,
        S_OUTR,
        S_WAIT,
        S_PUT
    } t_state;

    typedef enum logic [2:0] {
        OP_FB,
        OP_WETL,
        OP_WETR,
        OP_STG,
        OP_FBST,
        OP_OUTL,
        OP_OUTR
    } t_op;

endpackage

`default_nettype wire

// ===== design/sap_mac.sv =====
// Shared multiply-accumulate unit with saturation, three register stages.
// Depends on sap_pkg.
`default_nettype none

module sap_mac
    import sap_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mac_req i_req,
    output t_mac_rsp      o_rsp
);

    logic                       r_v1, r_v2, r_v3;
    logic signed [MUL_W-1:0]    r_coef1;
    logic signed [DIFF_W-1:0]   r_diff;
    logic signed [SAMPLE_W-1:0] r_add1, r_add2;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [SAMPLE_W-1:0] r_res;

    logic signed [PROD_W:0]     n_rnd;
    logic signed [PROD_W:0]     n_shr;
    logic signed [PROD_W+1:0]   n_tot;
    logic signed [SAMPLE_W-1:0] n_res;

    // Valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_req.start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Stage 1: exact difference; stage 2: product; stage 3: round, add, saturate
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_diff  <= DIFF_W'(i_req.p_val) - DIFF_W'(i_req.q_val);
            r_coef1 <= i_req.coef;
            r_add1  <= i_req.addend;
        end
        if (r_v1) begin
            r_prod  <= PROD_W'(r_coef1) * PROD_W'(r_diff);
            r_add2  <= r_add1;
        end
        if (r_v2) begin
            r_res   <= n_res;
        end
    end

    // Round half up, shift, accumulate, clamp to 24 bits
    always_comb begin
        n_rnd = (PROD_W+1)'(r_prod) + (PROD_W+1)'(1 <<< (Q_SHIFT - 1));
        n_shr = n_rnd >>> Q_SHIFT;
        n_tot = (PROD_W+2)'(n_shr) + (PROD_W+2)'(r_add2);
        if (n_tot > (PROD_W+2)'(SAMPLE_MAX)) begin
            n_res = SAMPLE_MAX;
        end else if (n_tot < (PROD_W+2)'(SAMPLE_MIN)) begin
            n_res = SAMPLE_MIN;
        end else begin
            n_res = n_tot[SAMPLE_W-1:0];
        end
    end

    assign o_rsp.valid  = r_v3;
    assign o_rsp.result = r_res;

endmodule

`default_nettype wire

// ===== design/sap_hist.sv =====
// Per-stage, per-channel x and y history memory with valid bits.
// Entries never written read as zero. Depends on sap_pkg.
`default_nettype none

module sap_hist
    import sap_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_rd_en,
    input  wire logic [ADDR_W-1:0]          i_rd_addr,
    input  wire logic                       i_wr_en,
    input  wire logic [ADDR_W-1:0]          i_wr_addr,
    input  wire logic signed [SAMPLE_W-1:0] i_wr_x,
    input  wire logic signed [SAMPLE_W-1:0] i_wr_y,
    output logic signed [SAMPLE_W-1:0]      o_rd_x,
    output logic signed [SAMPLE_W-1:0]      o_rd_y
);

    logic signed [SAMPLE_W-1:0] r_mem_x [DEPTH];
    logic signed [SAMPLE_W-1:0] r_mem_y [DEPTH];
    logic [DEPTH-1:0]           r_vld;

    // Valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // Storage write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_x[i_wr_addr] <= i_wr_x;
            r_mem_y[i_wr_addr] <= i_wr_y;
        end
    end

    // Registered read, zero for entries not yet written
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (r_vld[i_rd_addr]) begin
                o_rd_x <= r_mem_x[i_rd_addr];
                o_rd_y <= r_mem_y[i_rd_addr];
            end else begin
                o_rd_x <= '0;
                o_rd_y <= '0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/sap_seq.sv =====
// Sequencer: walks one item through feedback, the allpass stages and the
// mix, issuing one operation at a time to the shared unit.
// Depends on sap_pkg; drives sap_mac and sap_hist.
`default_nettype none

module sap_seq
    import sap_pkg::*;
#(
    parameter int MAX_STAGES = 8,
    parameter int ADDR_W     = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_cfg                       i_cfg,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic signed [SAMPLE_W-1:0] i_left_in,
    input  wire logic signed [SAMPLE_W-1:0] i_right_in,
    input  wire logic signed [COEF_W-1:0]   i_allpass_coef,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0]      o_left_out,
    output logic signed [SAMPLE_W-1:0]      o_right_out,
    output t_mac_req                        o_mac_req,
    input  wire t_mac_rsp                   i_mac_rsp,
    output logic                            o_hist_rd_en,
    output logic [ADDR_W-1:0]               o_hist_rd_addr,
    output logic                            o_hist_wr_en,
    output logic [ADDR_W-1:0]               o_hist_wr_addr,
    output logic signed [SAMPLE_W-1:0]      o_hist_wr_x,
    input  wire logic signed [SAMPLE_W-1:0] i_hist_rd_x,
    input  wire logic signed [SAMPLE_W-1:0] i_hist_rd_y
);

    localparam int SW = $clog2(MAX_STAGES + 1);

    t_state r_state, n_state;
    t_op    r_op;

    logic signed [SAMPLE_W-1:0] r_dry_l, r_dry_r;
    logic signed [COEF_W-1:0]   r_coef;
    logic [SW-1:0]              r_stages, n_stages;
    logic [SW-1:0]              r_st;
    logic                       r_ch;
    logic [ADDR_W-1:0]          r_addr, n_addr;
    logic signed [SAMPLE_W-1:0] r_fbt;
    logic signed [SAMPLE_W-1:0] r_wet_l, r_wet_r;
    logic signed [SAMPLE_W-1:0] r_res_l, r_res_r;
    logic signed [SAMPLE_W-1:0] r_fb;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_l, r_out_r;

    logic                       n_accept;
    logic                       n_done;
    logic                       n_last;
    logic                       n_slot_free;
    logic signed [SAMPLE_W:0]   n_sum;
    logic signed [SAMPLE_W-1:0] n_mean;
    logic signed [SAMPLE_W-1:0] n_x;

    assign n_accept    = (r_state == S_IDLE) && i_in_valid;
    assign n_done      = (r_state == S_WAIT) && i_mac_rsp.valid;
    assign n_last      = r_ch && (r_st == r_stages - SW'(1));
    assign n_slot_free = !r_out_valid || !i_out_stall;
    assign n_addr      = ADDR_W'({r_st, r_ch});
    assign n_x         = r_ch ? r_wet_r : r_wet_l;

    // Floor mean of the wet channels
    assign n_sum  = (SAMPLE_W+1)'(r_wet_l) + (SAMPLE_W+1)'(r_wet_r);
    assign n_mean = n_sum[SAMPLE_W:1];

    // Clamp the stage count
    always_comb begin
        if (int'(i_cfg.stage_count) > MAX_STAGES) begin
            n_stages = SW'(MAX_STAGES);
        end else begin
            n_stages = SW'(i_cfg.stage_count);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_FB;
            end
            S_FB, S_WETL, S_WETR, S_STG, S_MEAN, S_OUTL, S_OUTR: begin
                n_state = S_WAIT;
            end
            S_RD: begin
                n_state = S_STG;
            end
            S_WAIT: begin
                if (i_mac_rsp.valid) begin
                    unique case (r_op)
                        OP_FB:   n_state = S_WETL;
                        OP_WETL: n_state = S_WETR;
                        OP_WETR: n_state = (r_stages == '0) ? S_MEAN : S_RD;
                        OP_STG:  n_state = n_last ? S_MEAN : S_RD;
                        OP_FBST: n_state = S_OUTL;
                        OP_OUTL: n_state = S_OUTR;
                        OP_OUTR: n_state = S_PUT;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_PUT: begin
                if (n_slot_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Operation issue and memory control
    always_comb begin
        o_mac_req        = '0;
        o_hist_rd_en     = 1'b0;
        o_hist_rd_addr   = n_addr;
        o_hist_wr_en     = n_done && (r_op == OP_STG);
        o_hist_wr_addr   = r_addr;
        o_hist_wr_x      = n_x;
        o_in_stall       = (r_state != S_IDLE);
        unique case (r_state)
            S_FB: begin
                o_mac_req.start = 1'b1;
                o_mac_req.coef  = MUL_W'(i_cfg.feedback_gain);
                o_mac_req.p_val = r_fb;
            end
            S_WETL: begin
                o_mac_req.start  = 1'b1;
                o_mac_req.coef   = UNITY_GAIN;
                o_mac_req.p_val  = r_fbt;
                o_mac_req.addend = r_dry_l;
            end
            S_WETR: begin
                o_mac_req.start  = 1'b1;
                o_mac_req.coef   = UNITY_GAIN;
                o_mac_req.p_val  = r_fbt;
                o_mac_req.addend = r_dry_r;
            end
            S_RD: begin
                o_hist_rd_en = 1'b1;
            end
            S_STG: begin
                // y = x_prev + a * (y_prev - x)
                o_mac_req.start  = 1'b1;
                o_mac_req.coef   = MUL_W'(r_coef);
                o_mac_req.p_val  = i_hist_rd_y;
                o_mac_req.q_val  = n_x;
                o_mac_req.addend = i_hist_rd_x;
            end
            S_MEAN: begin
                o_mac_req.start = 1'b1;
                o_mac_req.coef  = MUL_W'(i_cfg.feedback_gain);
                o_mac_req.p_val = n_mean;
            end
            S_OUTL: begin
                o_mac_req.start  = 1'b1;
                o_mac_req.coef   = MUL_W'({1'b0, i_cfg.wet_mix});
                o_mac_req.p_val  = r_wet_l;
                o_mac_req.q_val  = r_dry_l;
                o_mac_req.addend = r_dry_l;
            end
            S_OUTR: begin
                o_mac_req.start  = 1'b1;
                o_mac_req.coef   = MUL_W'({1'b0, i_cfg.wet_mix});
                o_mac_req.p_val  = r_wet_r;
                o_mac_req.q_val  = r_dry_r;
                o_mac_req.addend = r_dry_r;
            end
            S_IDLE, S_WAIT, S_PUT: begin
            end
            default: begin
            end
        endcase
    end

    // Control state, feedback store and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fb        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (n_done && (r_op == OP_FBST)) begin
                r_fb <= i_mac_rsp.result;
            end
            if ((r_state == S_PUT) && n_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_dry_l  <= i_left_in;
            r_dry_r  <= i_right_in;
            r_coef   <= i_allpass_coef;
            r_stages <= n_stages;
            r_st     <= '0;
            r_ch     <= 1'b0;
        end
        unique case (r_state)
            S_FB:   r_op <= OP_FB;
            S_WETL: r_op <= OP_WETL;
            S_WETR: r_op <= OP_WETR;
            S_STG:  r_op <= OP_STG;
            S_MEAN: r_op <= OP_FBST;
            S_OUTL: r_op <= OP_OUTL;
            S_OUTR: r_op <= OP_OUTR;
            default: begin
            end
        endcase
        if (r_state == S_RD) begin
            r_addr <= n_addr;
        end
        if (n_done) begin
            unique case (r_op)
                OP_FB:   r_fbt   <= i_mac_rsp.result;
                OP_WETL: r_wet_l <= i_mac_rsp.result;
                OP_WETR: r_wet_r <= i_mac_rsp.result;
                OP_STG: begin
                    if (r_ch) begin
                        r_wet_r <= i_mac_rsp.result;
                        r_st    <= r_st + SW'(1);
                    end else begin
                        r_wet_l <= i_mac_rsp.result;
                    end
                    r_ch <= !r_ch;
                end
                OP_OUTL: r_res_l <= i_mac_rsp.result;
                OP_OUTR: r_res_r <= i_mac_rsp.result;
                default: begin
                end
            endcase
        end
        if ((r_state == S_PUT) && n_slot_free) begin
            r_out_l <= r_res_l;
            r_out_r <= r_res_r;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_out_l;
    assign o_right_out = r_out_r;

endmodule

`default_nettype wire

// ===== design/stereo_allpass_phaser_top.sv =====
// Each item runs as six operations on the 3-stage shared unit plus 2*S stage
// operations (one history read each) and one output step, S = clamped
// stage_count. A new item is taken only after the previous result has moved
// to the output register, which waits while the output is stalled.
// Reset (i_rst_n low, synchronous): history reads as zero, feedback store
// cleared, registers back to gain 0, mix 32768, four stages.
// Depends on sap_pkg, sap_mac, sap_hist and sap_seq.
`default_nettype none

module stereo_allpass_phaser_top
    import sap_pkg::*;
#(
    parameter int MAX_STAGES = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic signed [SAMPLE_W-1:0] i_left_in,
    input  wire logic signed [SAMPLE_W-1:0] i_right_in,
    input  wire logic signed [COEF_W-1:0]   i_allpass_coef,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0]      o_left_out,
    output logic signed [SAMPLE_W-1:0]      o_right_out
);

    localparam int DEPTH  = 2 * MAX_STAGES;
    localparam int ADDR_W = $clog2(DEPTH);

    t_cfg     r_cfg;
    t_mac_req w_mac_req;
    t_mac_rsp w_mac_rsp;

    logic                       w_rd_en, w_wr_en;
    logic [ADDR_W-1:0]          w_rd_addr, w_wr_addr;
    logic signed [SAMPLE_W-1:0] w_wr_x, w_rd_x, w_rd_y;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.feedback_gain <= RST_FEEDBACK_GAIN;
            r_cfg.wet_mix       <= RST_WET_MIX;
            r_cfg.stage_count   <= RST_STAGE_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FEEDBACK_GAIN: r_cfg.feedback_gain <= i_cfg_data;
                CFG_WET_MIX:       r_cfg.wet_mix       <= i_cfg_data;
                CFG_STAGE_COUNT:   r_cfg.stage_count   <= i_cfg_data[STAGE_CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    sap_seq #(
        .MAX_STAGES (MAX_STAGES),
        .ADDR_W     (ADDR_W)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_left_in      (i_left_in),
        .i_right_in     (i_right_in),
        .i_allpass_coef (i_allpass_coef),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_left_out     (o_left_out),
        .o_right_out    (o_right_out),
        .o_mac_req      (w_mac_req),
        .i_mac_rsp      (w_mac_rsp),
        .o_hist_rd_en   (w_rd_en),
        .o_hist_rd_addr (w_rd_addr),
        .o_hist_wr_en   (w_wr_en),
        .o_hist_wr_addr (w_wr_addr),
        .o_hist_wr_x    (w_wr_x),
        .i_hist_rd_x    (w_rd_x),
        .i_hist_rd_y    (w_rd_y)
    );

    sap_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mac_req),
        .o_rsp   (w_mac_rsp)
    );

    // The stage output written back is the shared unit's result
    sap_hist #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_x    (w_wr_x),
        .i_wr_y    (w_mac_rsp.result),
        .o_rd_x    (w_rd_x),
        .o_rd_y    (w_rd_y)
    );

endmodule

`default_nettype wire

// ===== tb/stereo_allpass_phaser_checker.sv =====
// Checker for the stereo allpass phaser: snoops the register port and both
// item channels, predicts every mixed output item and compares it.
// Depends on sap_pkg.
module stereo_allpass_phaser_checker
    import sap_pkg::*;
#(
    parameter int MAX_STAGES = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                       i_in_valid,
    input  wire logic                       i_in_stall,
    input  wire logic signed [SAMPLE_W-1:0] i_left_in,
    input  wire logic signed [SAMPLE_W-1:0] i_right_in,
    input  wire logic signed [COEF_W-1:0]   i_allpass_coef,
    input  wire logic                       i_out_valid,
    input  wire logic                       i_out_stall,
    input  wire logic signed [SAMPLE_W-1:0] i_left_out,
    input  wire logic signed [SAMPLE_W-1:0] i_right_out,
    output int                              o_fail_count,
    output int                              o_pending
);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } t_stereo;

    // Shadow registers and filter state
    longint      fb_gain;
    longint      mix_gain;
    int unsigned stage_sel;
    longint      x_hist [2*MAX_STAGES];
    longint      y_hist [2*MAX_STAGES];
    longint      fb_store;

    t_stereo mixed_q [$];
    t_stereo got;
    t_stereo want;
    int      fails = 0;

    function automatic longint clip24(input longint v);
        if (v > longint'(SAMPLE_MAX)) return longint'(SAMPLE_MAX);
        if (v < longint'(SAMPLE_MIN)) return longint'(SAMPLE_MIN);
        return v;
    endfunction

    // Q1.15 times sample, shifted back by 15, rounded half up
    function automatic longint qmul(input longint coef, input longint s);
        return (coef * s + 64'sd16384) >>> 15;
    endfunction

    // One sample through feedback, the allpass cascade and the mix
    function automatic t_stereo phaser_step(input longint l, input longint r,
                                            input longint a);
        longint      dry [2];
        longint      wet [2];
        longint      fb_term;
        longint      mean;
        longint      y;
        int unsigned n;
        int unsigned k;
        t_stereo     res;
        dry[0] = l;
        dry[1] = r;
        n = (stage_sel > MAX_STAGES) ? MAX_STAGES : stage_sel;
        fb_term = clip24(qmul(fb_gain, fb_store));
        for (int ch = 0; ch < 2; ch++)
            wet[ch] = clip24(dry[ch] + fb_term);
        for (int unsigned st = 0; st < n; st++) begin
            for (int ch = 0; ch < 2; ch++) begin
                k = 2 * st + ch;
                y = clip24(x_hist[k] + qmul(a, y_hist[k] - wet[ch]));
                x_hist[k] = wet[ch];
                y_hist[k] = y;
                wet[ch]   = y;
            end
        end
        // gain goes in here and again on the next sample
        mean = (wet[0] + wet[1]) >>> 1;
        fb_store = clip24(qmul(fb_gain, mean));
        res.left  = SAMPLE_W'(clip24(dry[0] + qmul(mix_gain, wet[0] - dry[0])));
        res.right = SAMPLE_W'(clip24(dry[1] + qmul(mix_gain, wet[1] - dry[1])));
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fb_gain   = 0;
            mix_gain  = 32768;
            stage_sel = 4;
            fb_store  = 0;
            for (int i = 0; i < 2 * MAX_STAGES; i++) begin
                x_hist[i] = 0;
                y_hist[i] = 0;
            end
            mixed_q.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FEEDBACK_GAIN: fb_gain = longint'($signed(i_cfg_data));
                    CFG_WET_MIX: mix_gain = longint'(i_cfg_data);
                    CFG_STAGE_COUNT: stage_sel = 32'(i_cfg_data[STAGE_CNT_W-1:0]);
                    default: ;
                endcase
            end
            // output item against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                got.left  = i_left_out;
                got.right = i_right_out;
                if (mixed_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("ERROR: unexpected output item L=%0d R=%0d",
                                 got.left, got.right);
                end else begin
                    want = mixed_q.pop_front();
                    if (want !== got) begin
                        fails++;
                        if (fails <= 10)
                            $display("ERROR: output mismatch L exp %0d got %0d, R exp %0d got %0d",
                                     want.left, got.left, want.right, got.right);
                    end
                end
            end
            // input item
            if (i_in_valid && !i_in_stall)
                mixed_q.push_back(phaser_step(longint'(i_left_in),
                                              longint'(i_right_in),
                                              longint'(i_allpass_coef)));
        end
        o_fail_count <= fails;
        o_pending    <= mixed_q.size();
    end

endmodule

// ===== tb/tb_stereo_allpass_phaser_top.sv =====
// Testbench top for the stereo allpass phaser: clock, reset, register
// phases, directed and random sample items, idling, watchdog and verdict.
// Depends on sap_pkg, stereo_allpass_phaser_top and the checker.
module tb_stereo_allpass_phaser_top;
    import sap_pkg::*;

    localparam int MAX_STAGES  = 8;
    localparam int WDOG_LIMIT  = 4000;
    localparam int DRAIN_WAIT  = 26 + 10 * MAX_STAGES + 14;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_idx = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] left_in = '0;
    logic signed [SAMPLE_W-1:0] right_in = '0;
    logic signed [COEF_W-1:0]   coef_in = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       quiet = 1'b0;
    int                         fail_count;
    int                         pending;
    int                         idle_cycles = 0;

    stereo_allpass_phaser_top #(.MAX_STAGES(MAX_STAGES)) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_left_in      (left_in),
        .i_right_in     (right_in),
        .i_allpass_coef (coef_in),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_left_out     (left_out),
        .o_right_out    (right_out)
    );

    stereo_allpass_phaser_checker #(.MAX_STAGES(MAX_STAGES)) i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_left_in      (left_in),
        .i_right_in     (right_in),
        .i_allpass_coef (coef_in),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_left_out     (left_out),
        .i_right_out    (right_out),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Output back-pressure, off during quiet stretches
    always @(posedge i_clk) begin
        out_stall <= !quiet && ($urandom_range(99) < 15);
    end

    // Watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("ERROR: no item accepted for %0d cycles", WDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one sample item and wait until it is taken
    task automatic send_item(input logic signed [SAMPLE_W-1:0] l,
                             input logic signed [SAMPLE_W-1:0] r,
                             input logic signed [COEF_W-1:0]   c);
        if (!quiet && $urandom_range(99) < 20) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(60, 1)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        left_in  <= l;
        right_in <= r;
        coef_in  <= c;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    // Stop sending and wait until every predicted item has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all registers, upper stage-count bits carry junk
    task automatic load_config(input logic [CFG_DATA_W-1:0]  gain,
                               input logic [CFG_DATA_W-1:0]  mix,
                               input logic [STAGE_CNT_W-1:0] stages,
                               input logic                   poke_spare);
        logic [CFG_DATA_W-STAGE_CNT_W-1:0] junk;
        logic [CFG_DATA_W-1:0]             spare_val;
        junk      = (CFG_DATA_W-STAGE_CNT_W)'($urandom);
        spare_val = CFG_DATA_W'($urandom);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_FEEDBACK_GAIN;
        cfg_data <= gain;
        @(posedge i_clk);
        cfg_idx  <= CFG_WET_MIX;
        cfg_data <= mix;
        @(posedge i_clk);
        cfg_idx  <= CFG_STAGE_COUNT;
        cfg_data <= {junk, stages};
        @(posedge i_clk);
        if (poke_spare) begin
            cfg_idx  <= CFG_SPARE;
            cfg_data <= spare_val;
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        logic signed [11:0]         near_zero;
        logic signed [SAMPLE_W-1:0] full;
        near_zero = 12'($urandom);
        full      = SAMPLE_W'($urandom);
        case ($urandom_range(7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return SAMPLE_W'(near_zero);
            default: return full;
        endcase
    endfunction

    function automatic logic signed [COEF_W-1:0] rand_coef();
        logic signed [COEF_W-1:0] full;
        full = COEF_W'($urandom);
        case ($urandom_range(7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return '0;
            default: return full;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_gain();
        logic signed [11:0] mild;
        mild = 12'($urandom);
        case ($urandom_range(3))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'(mild);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_mix();
        case ($urandom_range(4))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'hFFFF;
            3: return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(32768));
        endcase
    endfunction

    function automatic logic [STAGE_CNT_W-1:0] rand_stages();
        if ($urandom_range(8) == 0)
            return STAGE_CNT_W'($urandom_range(15, 9));
        return STAGE_CNT_W'($urandom_range(MAX_STAGES));
    endfunction

    // Main sequence
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: no feedback, fully wet, four stages
        send_item(SAMPLE_MAX, SAMPLE_MAX, 16'sh7FFF);
        send_item(SAMPLE_MIN, SAMPLE_MIN, 16'sh8000);
        send_item(SAMPLE_MAX, SAMPLE_MIN, 16'sh0000);
        send_item(SAMPLE_MIN, SAMPLE_MAX, 16'sh8000);
        send_item(24'sd0, 24'sd0, 16'sh7FFF);
        send_item(24'sd1, -24'sd1, -16'sd1);

        // full positive feedback, over-unity mix, all stages
        settle();
        load_config(16'h7FFF, 16'hFFFF, 4'd8, 1'b1);
        send_item(SAMPLE_MAX, SAMPLE_MAX, 16'sh7FFF);
        send_item(SAMPLE_MIN, SAMPLE_MIN, 16'sh8000);
        send_item(SAMPLE_MAX, SAMPLE_MIN, 16'sh7FFF);
        send_item(24'sd0, 24'sd0, 16'sh0000);

        // no stages, dry only, most negative feedback
        settle();
        load_config(16'h8000, 16'd0, 4'd0, 1'b0);
        send_item(SAMPLE_MAX, SAMPLE_MIN, 16'sh8000);
        send_item(SAMPLE_MIN, SAMPLE_MAX, 16'sh7FFF);
        send_item(24'sd12345, -24'sd54321, 16'sd1000);

        // stage count above the maximum gets clamped
        settle();
        load_config(16'h8000, 16'hFFFF, 4'd15, 1'b0);
        send_item(SAMPLE_MAX, SAMPLE_MAX, 16'sh8000);
        send_item(SAMPLE_MIN, SAMPLE_MIN, 16'sh7FFF);
        send_item(SAMPLE_MAX, SAMPLE_MIN, -16'sd1);
        send_item(-24'sd1, 24'sd1, 16'sd1);

        // single stage, drive the feedback loop into saturation
        settle();
        load_config(16'h7FFF, 16'd32768, 4'd1, 1'b0);
        repeat (3) send_item(SAMPLE_MAX, SAMPLE_MAX, 16'sh7FFF);

        // random phases, one of them without any idling
        for (int ph = 0; ph < 10; ph++) begin
            settle();
            quiet <= (ph == 3);
            load_config(rand_gain(), rand_mix(), rand_stages(), 1'b0);
            repeat (200) send_item(rand_sample(), rand_sample(), rand_coef());
        end

        settle();
        quiet <= 1'b0;
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
